// ----- design/align_z_rotation_transform_macros.svh -----
// assertion helpers shared by the rotation block
`ifndef ALIGN_Z_ROTATION_TRANSFORM_MACROS_SVH
`define ALIGN_Z_ROTATION_TRANSFORM_MACROS_SVH

// same-cycle implication
`define AZR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("azr check failed");

// next-cycle implication
`define AZR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("azr check failed");

`endif

// ----- design/azr_pkg.sv -----
`timescale 1ns / 1ps
package azr_pkg;

   parameter int FRAC_BITS  = 14;
   parameter int FIELD_W    = 16;
   parameter int LANES      = 3;
   parameter int WORD_W     = LANES * FIELD_W;
   parameter int CSR_ADDR_W = 2;

   // one + up_z, signed, and its magnitude
   parameter int D_W  = ((FRAC_BITS + 1 > FIELD_W) ? FRAC_BITS + 1 : FIELD_W) + 1;
   parameter int UD_W = D_W - 1;

   parameter int PROD_W = 2 * FIELD_W;
   parameter int P_W    = PROD_W + 1;
   parameter int S_W    = PROD_W;
   parameter int N_W    = FIELD_W + P_W;
   parameter int NUM_W  = N_W - 1;

   // pipelined long division, two quotient bits per stage
   parameter int DIV_STEP   = 2;
   parameter int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
   parameter int DIVD_W     = DIV_STAGES * DIV_STEP;

   parameter int LIN_W = ((FIELD_W + FRAC_BITS > P_W) ? FIELD_W + FRAC_BITS : P_W) + 1;
   parameter int G_W   = ((LIN_W > DIVD_W + 1) ? LIN_W : DIVD_W + 1) + 1;
   parameter int R_W   = G_W - FRAC_BITS;

   parameter int FRONT_STAGES = 4;
   parameter int BACK_STAGES  = 2;
   parameter int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

   parameter logic signed [D_W-1:0] ONE_D  = D_W'(64'd1 << FRAC_BITS);
   parameter logic signed [G_W-1:0] HALF_G = G_W'(64'd1 << (FRAC_BITS - 1));

   parameter logic signed [FIELD_W-1:0] UP_X_RESET = '0;
   parameter logic signed [FIELD_W-1:0] UP_Y_RESET = '0;
   parameter logic signed [FIELD_W-1:0] UP_Z_RESET = FIELD_W'(16384);

   parameter logic signed [FIELD_W-1:0] SAT_MAX = {1'b0, {(FIELD_W - 1){1'b1}}};
   parameter logic signed [FIELD_W-1:0] SAT_MIN = {1'b1, {(FIELD_W - 1){1'b0}}};

   parameter logic [CSR_ADDR_W-1:0] REG_UP_X = 2'd0;
   parameter logic [CSR_ADDR_W-1:0] REG_UP_Y = 2'd1;
   parameter logic [CSR_ADDR_W-1:0] REG_UP_Z = 2'd2;

   typedef enum logic [1:0] {
      MODE_GENERAL  = 2'd0,
      MODE_IDENTITY = 2'd1,
      MODE_NEGATE   = 2'd2
   } mode_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] up_x;
      logic signed [FIELD_W-1:0] up_y;
      logic [UD_W-1:0]           ud;
      logic                      d_neg;
      mode_type                  mode;
   } cfg_type;

   typedef struct packed {
      logic                    neg;
      logic [UD_W-1:0]         rem;
      logic [DIVD_W-1:0]       nq;
      logic signed [LIN_W-1:0] lin;
   } lane_type;

endpackage

// ----- design/azr_front.sv -----
`timescale 1ns / 1ps
module azr_front (
   input  logic                                     clock,
   input  logic                                     adv,
   input  azr_pkg::cfg_type                         cfg,
   input  logic signed [azr_pkg::FIELD_W-1:0]       local_x,
   input  logic signed [azr_pkg::FIELD_W-1:0]       local_y,
   input  logic signed [azr_pkg::FIELD_W-1:0]       local_z,
   output azr_pkg::lane_type [azr_pkg::LANES-1:0]   lanes
);
   import azr_pkg::*;

   // stage 1: products
   logic signed [FIELD_W-1:0] lx1_ff, lx1_in, ly1_ff, ly1_in, lz1_ff, lz1_in;
   logic signed [PROD_W-1:0]  pxx1_ff, pxx1_in, pyy1_ff, pyy1_in;
   logic signed [PROD_W-1:0]  pzx1_ff, pzx1_in, pzy1_ff, pzy1_in;
   logic signed [PROD_W-1:0]  sqx1_ff, sqx1_in, sqy1_ff, sqy1_in;
   // stage 2: dot product, squared norm, linear x/y terms
   logic signed [P_W-1:0]     p2_ff, p2_in;
   logic [S_W-1:0]            s2_ff, s2_in;
   logic signed [LIN_W-1:0]   linx2_ff, linx2_in, liny2_ff, liny2_in;
   logic signed [FIELD_W-1:0] lz2_ff, lz2_in;
   // stage 3: numerators of the three quotients
   logic signed [N_W-1:0]     n3_ff [LANES];
   logic signed [N_W-1:0]     n3_in [LANES];
   logic signed [LIN_W-1:0]   lin3_ff [LANES];
   logic signed [LIN_W-1:0]   lin3_in [LANES];
   // stage 4: rounded dividend magnitudes
   lane_type [LANES-1:0]      lanes4_ff, lanes4_in;

   logic signed [LIN_W-1:0]   lxs, lys, lzs;
   logic [UD_W-1:0]           hud;
   logic [N_W-1:0]            t4;

   always_comb begin
      lx1_in  = local_x;
      ly1_in  = local_y;
      lz1_in  = local_z;
      pxx1_in = local_x * $signed(cfg.up_x);
      pyy1_in = local_y * $signed(cfg.up_y);
      pzx1_in = local_z * $signed(cfg.up_x);
      pzy1_in = local_z * $signed(cfg.up_y);
      sqx1_in = $signed(cfg.up_x) * $signed(cfg.up_x);
      sqy1_in = $signed(cfg.up_y) * $signed(cfg.up_y);
   end

   always_comb begin
      lxs      = $signed(LIN_W'(lx1_ff)) <<< FRAC_BITS;
      lys      = $signed(LIN_W'(ly1_ff)) <<< FRAC_BITS;
      p2_in    = $signed(P_W'(pxx1_ff)) + $signed(P_W'(pyy1_ff));
      s2_in    = $unsigned(sqx1_ff) + $unsigned(sqy1_ff);
      lz2_in   = lz1_ff;
      case (cfg.mode)
         MODE_IDENTITY: begin
            linx2_in = lxs;
            liny2_in = lys;
         end
         MODE_NEGATE: begin
            linx2_in = -lxs;
            liny2_in = -lys;
         end
         MODE_GENERAL: begin
            linx2_in = lxs + $signed(LIN_W'(pzx1_ff));
            liny2_in = lys + $signed(LIN_W'(pzy1_ff));
         end
         default: begin
            linx2_in = lxs + $signed(LIN_W'(pzx1_ff));
            liny2_in = lys + $signed(LIN_W'(pzy1_ff));
         end
      endcase
   end

   always_comb begin
      lzs        = $signed(LIN_W'(lz2_ff)) <<< FRAC_BITS;
      n3_in[0]   = $signed(cfg.up_x) * p2_ff;
      n3_in[1]   = $signed(cfg.up_y) * p2_ff;
      n3_in[2]   = lz2_ff * $signed({1'b0, s2_ff});
      lin3_in[0] = linx2_ff;
      lin3_in[1] = liny2_ff;
      case (cfg.mode)
         MODE_IDENTITY: lin3_in[2] = lzs;
         MODE_NEGATE:   lin3_in[2] = -lzs;
         MODE_GENERAL:  lin3_in[2] = lzs - $signed(LIN_W'(p2_ff));
         default:       lin3_in[2] = lzs - $signed(LIN_W'(p2_ff));
      endcase
   end

   // |n| + |d|/2, ready for a floor division; zero in the pole cases
   always_comb begin
      hud = cfg.ud >> 1;
      t4  = '0;
      for (int l = 0; l < LANES; l++) begin
         if (n3_ff[l][N_W-1]) begin
            t4 = N_W'(hud) - $unsigned(n3_ff[l]);
         end else begin
            t4 = $unsigned(n3_ff[l]) + N_W'(hud);
         end
         lanes4_in[l].rem = '0;
         lanes4_in[l].lin = lin3_ff[l];
         if (cfg.mode == MODE_GENERAL) begin
            lanes4_in[l].nq  = DIVD_W'(t4[NUM_W-1:0]);
            lanes4_in[l].neg = n3_ff[l][N_W-1] ^ cfg.d_neg;
         end else begin
            lanes4_in[l].nq  = '0;
            lanes4_in[l].neg = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lx1_ff    <= lx1_in;
         ly1_ff    <= ly1_in;
         lz1_ff    <= lz1_in;
         pxx1_ff   <= pxx1_in;
         pyy1_ff   <= pyy1_in;
         pzx1_ff   <= pzx1_in;
         pzy1_ff   <= pzy1_in;
         sqx1_ff   <= sqx1_in;
         sqy1_ff   <= sqy1_in;
         p2_ff     <= p2_in;
         s2_ff     <= s2_in;
         linx2_ff  <= linx2_in;
         liny2_ff  <= liny2_in;
         lz2_ff    <= lz2_in;
         n3_ff     <= n3_in;
         lin3_ff   <= lin3_in;
         lanes4_ff <= lanes4_in;
      end
   end

   assign lanes = lanes4_ff;

endmodule

// ----- design/azr_div_stage.sv -----
`timescale 1ns / 1ps
module azr_div_stage (
   input  logic                                   clock,
   input  logic                                   adv,
   input  logic [azr_pkg::UD_W-1:0]               ud,
   input  azr_pkg::lane_type [azr_pkg::LANES-1:0] lanes_i,
   output azr_pkg::lane_type [azr_pkg::LANES-1:0] lanes_o
);
   import azr_pkg::*;

   lane_type [LANES-1:0] lanes_ff, lanes_in;

   // restoring division: dividend bits shift out the top of nq,
   // quotient bits shift in at the bottom
   always_comb begin : div_steps
      logic [UD_W:0]     r_ext;
      logic [UD_W-1:0]   rem;
      logic [DIVD_W-1:0] nq;
      logic              qbit;
      lanes_in = lanes_i;
      for (int l = 0; l < LANES; l++) begin
         rem = lanes_i[l].rem;
         nq  = lanes_i[l].nq;
         for (int k = 0; k < DIV_STEP; k++) begin
            r_ext = {rem, nq[DIVD_W-1]};
            if (r_ext >= {1'b0, ud}) begin
               rem  = UD_W'(r_ext - {1'b0, ud});
               qbit = 1'b1;
            end else begin
               rem  = r_ext[UD_W-1:0];
               qbit = 1'b0;
            end
            nq = {nq[DIVD_W-2:0], qbit};
         end
         lanes_in[l].rem = rem;
         lanes_in[l].nq  = nq;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lanes_ff <= lanes_in;
      end
   end

   assign lanes_o = lanes_ff;

endmodule

// ----- design/azr_back.sv -----
`timescale 1ns / 1ps
module azr_back (
   input  logic                                   clock,
   input  logic                                   adv,
   input  azr_pkg::lane_type [azr_pkg::LANES-1:0] lanes_i,
   output logic signed [azr_pkg::FIELD_W-1:0]     global_x,
   output logic signed [azr_pkg::FIELD_W-1:0]     global_y,
   output logic signed [azr_pkg::FIELD_W-1:0]     global_z
);
   import azr_pkg::*;

   logic signed [G_W-1:0]     g_ff [LANES];
   logic signed [G_W-1:0]     g_in [LANES];
   logic signed [FIELD_W-1:0] res_ff [LANES];
   logic signed [FIELD_W-1:0] res_in [LANES];

   logic signed [G_W-1:0] lin_ext, q_ext, biased;
   logic signed [R_W-1:0] rnd;

   // apply the quotient sign while subtracting it from the linear part
   always_comb begin
      lin_ext = '0;
      q_ext   = '0;
      for (int l = 0; l < LANES; l++) begin
         lin_ext = $signed(G_W'($signed(lanes_i[l].lin)));
         q_ext   = $signed(G_W'(lanes_i[l].nq));
         g_in[l] = lanes_i[l].neg ? lin_ext + q_ext : lin_ext - q_ext;
      end
   end

   // drop the fraction, round half away from zero, then clamp
   always_comb begin
      biased = '0;
      rnd    = '0;
      for (int l = 0; l < LANES; l++) begin
         biased = g_ff[l] + (g_ff[l][G_W-1] ? HALF_G - G_W'(1) : HALF_G);
         rnd    = R_W'(biased >>> FRAC_BITS);
         if (rnd > $signed(R_W'(SAT_MAX))) begin
            res_in[l] = SAT_MAX;
         end else if (rnd < $signed(R_W'(SAT_MIN))) begin
            res_in[l] = SAT_MIN;
         end else begin
            res_in[l] = rnd[FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_ff   <= g_in;
         res_ff <= res_in;
      end
   end

   assign global_x = res_ff[0];
   assign global_y = res_ff[1];
   assign global_z = res_ff[2];

endmodule

// ----- design/align_z_rotation_transform.sv -----
// pipeline from the accepting edge to rsp_tvalid: the quotient divider, 24 stages of two bits each,
//   plus four front stages, two back stages and the output register
// throughput: one word per clock; a full output register plus skid stall the pipeline
// reset: synchronous, active high; pole returns to (0, 0, 1.0), pipeline and output empty
`timescale 1ns / 1ps
`include "align_z_rotation_transform_macros.svh"
module align_z_rotation_transform (
   input  logic                              clock,
   input  logic                              reset,
   // request words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [azr_pkg::WORD_W-1:0]        req_tdata,   // local_x, local_y, local_z
   // response words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [azr_pkg::WORD_W-1:0]        rsp_tdata,   // global_x, global_y, global_z
   // register writes
   input  logic                              csr_we,
   input  logic [azr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [azr_pkg::FIELD_W-1:0]       csr_wdata
);
   import azr_pkg::*;

   // pole vector registers
   logic signed [FIELD_W-1:0] up_x_ff, up_x_in, up_y_ff, up_y_in, up_z_ff, up_z_in;

   // derived divisor and mode; the user must keep them static while words are in flight, the block does not enforce it
   cfg_type               cfg;
   logic signed [D_W-1:0] up_z_ext, d_val, d_abs;

   // pipeline control
   logic                   adv;
   logic                   last_valid;
   logic                   up_valid;
   logic [PIPE_STAGES-1:0] pv_ff, pv_in;

   lane_type [LANES-1:0] div_lanes [DIV_STAGES + 1];

   logic signed [FIELD_W-1:0] res_x, res_y, res_z;
   logic [WORD_W-1:0]         res_word;

   // output register and skid
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   logic [WORD_W-1:0] skid_data_ff, skid_data_in;

   // register file
   always_comb begin
      up_x_in = up_x_ff;
      up_y_in = up_y_ff;
      up_z_in = up_z_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_UP_X: up_x_in = csr_wdata;
            REG_UP_Y: up_y_in = csr_wdata;
            REG_UP_Z: up_z_in = csr_wdata;
            default:  ;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_x_ff <= UP_X_RESET;
         up_y_ff <= UP_Y_RESET;
         up_z_ff <= UP_Z_RESET;
      end else begin
         up_x_ff <= up_x_in;
         up_y_ff <= up_y_in;
         up_z_ff <= up_z_in;
      end
   end

   // d = one + up_z; pole at +1 passes through, pole at -1 negates,
   // and the divisor is forced to one there so the divider sees no zero
   always_comb begin
      up_z_ext  = $signed(D_W'(up_z_ff));
      d_val     = ONE_D + up_z_ext;
      d_abs     = d_val[D_W-1] ? -d_val : d_val;
      cfg.up_x  = up_x_ff;
      cfg.up_y  = up_y_ff;
      cfg.d_neg = d_val[D_W-1];
      if (up_z_ext == ONE_D) begin
         cfg.mode = MODE_IDENTITY;
      end else if (up_z_ext == -ONE_D) begin
         cfg.mode = MODE_NEGATE;
      end else begin
         cfg.mode = MODE_GENERAL;
      end
      cfg.ud = (cfg.mode == MODE_NEGATE) ? UD_W'(1) : d_abs[UD_W-1:0];
   end

   // the whole pipeline moves together while the skid is empty
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign last_valid = pv_ff[PIPE_STAGES-1];
   assign up_valid   = last_valid && adv;

   always_comb begin
      pv_in = {pv_ff[PIPE_STAGES-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
      end else if (adv) begin
         pv_ff <= pv_in;
      end
   end

   // products, sums and dividend setup
   azr_front u_front (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg),
      .local_x (req_tdata[FIELD_W-1:0]),
      .local_y (req_tdata[2*FIELD_W-1:FIELD_W]),
      .local_z (req_tdata[3*FIELD_W-1:2*FIELD_W]),
      .lanes   (div_lanes[0])
   );

   // quotient by |d|, all three lanes side by side
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      azr_div_stage u_div_stage (
         .clock   (clock),
         .adv     (adv),
         .ud      (cfg.ud),
         .lanes_i (div_lanes[i]),
         .lanes_o (div_lanes[i+1])
      );
   end

   // sign, rounding and saturation
   azr_back u_back (
      .clock    (clock),
      .adv      (adv),
      .lanes_i  (div_lanes[DIV_STAGES]),
      .global_x (res_x),
      .global_y (res_y),
      .global_z (res_z)
   );

   assign res_word = {res_z, res_y, res_x};

   // output register with a one-word skid behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_data_in  = res_word;
            out_valid_in = last_valid;
         end
      end else if (up_valid) begin
         // output held, park the word leaving the pipeline
         skid_data_in  = res_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // skid only ever holds a word while the output register is occupied
   `AZR_ASSERT_IMP(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff)
   // a stalled pipeline keeps its valid bits
   `AZR_ASSERT_NXT(a_stall_freezes_pipe, clock, reset, !adv, $stable(pv_ff))
   // a word leaving the pipeline into a held output lands in the skid
   `AZR_ASSERT_NXT(a_skid_catches, clock, reset, up_valid && out_valid_ff && !rsp_tready, skid_valid_ff)

endmodule

// ----- tb/azr_rotation_checker.sv -----
`timescale 1ns / 1ps
module azr_rotation_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [azr_pkg::WORD_W-1:0]        req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [azr_pkg::WORD_W-1:0]        rsp_tdata,
   input  logic                              csr_we,
   input  logic [azr_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [azr_pkg::FIELD_W-1:0]       csr_wdata,
   output int                                mismatches,
   output int                                rotations_pending,
   output int                                rotations_checked
);
   import azr_pkg::*;

   typedef logic signed [FIELD_W-1:0] coord_type;
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec3_type;

   // shadow copy of the pole registers
   coord_type pole_x;
   coord_type pole_y;
   coord_type pole_z;

   vec3_type expected_rotations[$];

   // quotient rounded to nearest, ties away from zero
   function automatic longint round_div(longint num, longint den);
      bit     neg;
      longint un;
      longint ud;
      longint q;
      neg = (num < 0) != (den < 0);
      un  = (num < 0) ? -num : num;
      ud  = (den < 0) ? -den : den;
      q   = (un + ud / 2) / ud;
      return neg ? -q : q;
   endfunction

   function automatic coord_type clamp16(longint v);
      if (v > longint'(SAT_MAX)) return SAT_MAX;
      if (v < longint'(SAT_MIN)) return SAT_MIN;
      return coord_type'(v);
   endfunction

   function automatic vec3_type unpack_word(logic [WORD_W-1:0] word);
      vec3_type v;
      v.x = word[0 +: FIELD_W];
      v.y = word[FIELD_W +: FIELD_W];
      v.z = word[2*FIELD_W +: FIELD_W];
      return v;
   endfunction

   function automatic vec3_type rotate_to_pole(vec3_type lv);
      longint   one, den, p, s;
      longint   x, y, z, ux, uy, uz;
      longint   gx, gy, gz;
      vec3_type r;
      one = longint'(1) << FRAC_BITS;
      x   = lv.x;
      y   = lv.y;
      z   = lv.z;
      ux  = pole_x;
      uy  = pole_y;
      uz  = pole_z;
      if (uz == one) begin
         r.x = clamp16(x);
         r.y = clamp16(y);
         r.z = clamp16(z);
         return r;
      end
      if (uz == -one) begin
         r.x = clamp16(-x);
         r.y = clamp16(-y);
         r.z = clamp16(-z);
         return r;
      end
      den = one + uz;
      p   = x * ux + y * uy;
      s   = ux * ux + uy * uy;
      gx  = x * one + z * ux - round_div(ux * p, den);
      gy  = y * one + z * uy - round_div(uy * p, den);
      gz  = z * one - p - round_div(z * s, den);
      r.x = clamp16(round_div(gx, one));
      r.y = clamp16(round_div(gy, one));
      r.z = clamp16(round_div(gz, one));
      return r;
   endfunction

   task automatic report_lane(string lane, coord_type want, coord_type got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, lane, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      vec3_type want;
      vec3_type got;
      if (reset) begin
         expected_rotations.delete();
         pole_x = UP_X_RESET;
         pole_y = UP_Y_RESET;
         pole_z = UP_Z_RESET;
         mismatches = 0;
         rotations_checked = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_UP_X: pole_x = csr_wdata;
               REG_UP_Y: pole_y = csr_wdata;
               REG_UP_Z: pole_z = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_rotations.push_back(rotate_to_pole(unpack_word(req_tdata)));
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_word(rsp_tdata);
            if (expected_rotations.size() == 0) begin
               $display("%0t ns: result word %h with nothing expected", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_rotations.pop_front();
               report_lane("global_x", want.x, got.x);
               report_lane("global_y", want.y, got.y);
               report_lane("global_z", want.z, got.z);
               rotations_checked++;
            end
         end
      end
      rotations_pending = expected_rotations.size();
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import azr_pkg::*;

   typedef logic signed [FIELD_W-1:0] coord_type;

   // how the receiver paces rsp_tready
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   // index 3 decodes to no register and must be ignored
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE = 2'd3;

   localparam int HOLD_OFF_CYCLES = 300;   // long enough to back up the whole pipeline
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES    = 40;    // covers the pipeline latency, plus margin
   localparam int PHASE_WORDS     = 86;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [WORD_W-1:0]     req_tdata;    // local_x, local_y, local_z
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [WORD_W-1:0]     rsp_tdata;    // global_x, global_y, global_z
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [FIELD_W-1:0]    csr_wdata;

   int mismatches;
   int rotations_pending;
   int rotations_checked;

   bit hold_off_request;   // set by the stimulus, consumed by the receiver
   int burst_left;
   int poles_loaded;

   align_z_rotation_transform dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   azr_rotation_checker pole_check (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .mismatches        (mismatches),
      .rotations_pending (rotations_pending),
      .rotations_checked (rotations_checked)
   );

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // word layout: x in the low lane, z in the high lane
   function automatic logic [WORD_W-1:0] pack_word(coord_type x, coord_type y, coord_type z);
      return {z, y, x};
   endfunction

   // biased toward the rails and small magnitudes, rest full range
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return SAT_MAX;
         1: return SAT_MIN;
         2: return coord_type'(int'($urandom_range(0, 32768)) - 16384);
         3: return coord_type'(int'($urandom_range(0, 512)) - 256);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic coord_type rand_pole_coord();
      return coord_type'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   // offer one word and hold it until taken; returns on the next falling edge
   task automatic send_word(input logic [WORD_W-1:0] word);
      req_tdata  <= word;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // stop offering and wait until every result is back
   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (rotations_pending != 0) @(negedge clock);
   endtask

   // pole writes only happen with the block empty
   task automatic load_pole(input coord_type ux, input coord_type uy, input coord_type uz);
      csr_we    <= 1'b1;
      csr_addr  <= REG_UP_X;
      csr_wdata <= ux;
      @(negedge clock);
      csr_addr  <= REG_UP_Y;
      csr_wdata <= uy;
      @(negedge clock);
      csr_addr  <= REG_UP_Z;
      csr_wdata <= uz;
      @(negedge clock);
      // stray write to the unused index, must not disturb the pole
      csr_addr  <= REG_SPARE;
      csr_wdata <= coord_type'($urandom);
      @(negedge clock);
      csr_we    <= 1'b0;
      poles_loaded++;
   endtask

   // random direction scaled to unit length in Q2.14
   task automatic load_random_unit_pole();
      real rx, ry, rz, len;
      rx  = real'(int'($urandom_range(0, 65536)) - 32768);
      ry  = real'(int'($urandom_range(0, 65536)) - 32768);
      rz  = real'(int'($urandom_range(0, 65536)) - 32768);
      len = $sqrt(rx * rx + ry * ry + rz * rz);
      if (len < 1.0)
         load_pole(0, 0, 16384);
      else
         load_pole(coord_type'($rtoi(rx * 16384.0 / len)),
                   coord_type'($rtoi(ry * 16384.0 / len)),
                   coord_type'($rtoi(rz * 16384.0 / len)));
   endtask

   // rails, axes and mixed signs, sent back to back
   task automatic run_corner_vectors();
      send_word(pack_word(0, 0, 0));
      send_word(pack_word(SAT_MAX, SAT_MAX, SAT_MAX));
      send_word(pack_word(SAT_MIN, SAT_MIN, SAT_MIN));
      send_word(pack_word(16384, 0, 0));
      send_word(pack_word(0, 16384, 0));
      send_word(pack_word(0, 0, 16384));
      send_word(pack_word(SAT_MAX, SAT_MIN, 1));
      send_word(pack_word(-1, -1, -1));
      drain_all();
   endtask

   // random words in bursts; optional receiver hold-off or mid-phase pause
   task automatic run_phase(input int count, input bit with_gaps, input bit hold_off,
                            input bit mid_pause);
      int gap;
      for (int i = 0; i < count; i++) begin
         if (hold_off && i == 10) hold_off_request = 1'b1;
         if (mid_pause && i == count / 2) drain_all();
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = with_gaps ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
         send_word(pack_word(rand_coord(), rand_coord(), rand_coord()));
      end
      drain_all();
   endtask

   // receiver: picks a new random pacing mode when the current one runs out, plus one long hold-off on request
   initial begin : receiver
      int             hold_left;
      int             mode_left;
      int             beat;
      ready_mode_type ready_mode;
      hold_left  = 0;
      mode_left  = 0;
      beat       = 0;
      ready_mode = READY_ALWAYS;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         beat++;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = ready_mode_type'($urandom_range(0, 3));
               mode_left  = $urandom_range(16, 128);
            end
            mode_left--;
            case (ready_mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:      rsp_tready <= (beat % 7) < 4;
            endcase
         end
      end
   end

   // watchdog: too long without any handshake means the block is stuck
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, rotations_pending);
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      csr_we           = 1'b0;
      csr_addr         = '0;
      csr_wdata        = '0;
      hold_off_request = 1'b0;
      burst_left       = 0;
      poles_loaded     = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset pole (pass-through), pole at minus one, 45 degree tilt
      run_corner_vectors();
      load_pole(0, 0, -16384);
      run_corner_vectors();
      load_pole(11585, 0, 11585);
      run_corner_vectors();

      // random: fixed poles covering the special cases and the rails
      load_pole(0, 0, 16384);
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b0);
      load_pole(0, 0, -16384);
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b0);
      load_pole(16384, 0, 0);
      run_phase(PHASE_WORDS, 1'b1, 1'b1, 1'b0);       // receiver holds off here
      load_pole(0, -16384, 0);
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b1);       // sender pauses until empty
      load_pole(16384, 16384, -16383);                // divisor of one, heavy saturation
      run_phase(PHASE_WORDS, 1'b0, 1'b0, 1'b0);
      load_pole(-16384, -16384, 16384);               // pass-through despite tilt terms
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b0);
      load_pole(-16384, 16384, -16384);               // negation despite tilt terms
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b0);
      load_pole(0, 0, 0);                             // zero-length pole
      run_phase(PHASE_WORDS, 1'b0, 1'b0, 1'b0);
      load_pole(16384, -16384, 0);                    // non-unit pole
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b0);
      load_pole(-16384, 0, -16383);                   // just short of the antipode
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b0);

      // random unit poles and random non-unit poles
      repeat (3) begin
         load_random_unit_pole();
         run_phase(PHASE_WORDS, 1'($urandom_range(0, 1)), 1'b0, 1'b0);
      end
      load_pole(rand_pole_coord(), rand_pole_coord(), rand_pole_coord());
      run_phase(PHASE_WORDS, 1'b1, 1'b0, 1'b0);

      // everything already drained, let the pipeline settle
      while (rotations_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d rotated words over %0d pole settings", rotations_checked,
               poles_loaded + 1);
      $display("pass-through, negation, axis, near-antipodal, non-unit and random unit poles");
      if (mismatches == 0 && rotations_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
